// ===== hdl/dtf_pkg.sv =====
package dtf_pkg;

	// mode encoding; live is kept as a code but never entered
	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_VIDEO = 2'd1,
		MODE_LIVE  = 2'd2
	} mode_t;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_PRIMARY_THR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_THR     = 1'd1;

	localparam int unsigned THR_W = 8;
	localparam logic [THR_W-1:0] THR_RESET = 8'd3;

	// absence counter: 7 bits, latch released at 90 absent frames
	localparam int unsigned ABSENT_W = 7;
	localparam logic [ABSENT_W-1:0] ABSENT_LIMIT = 7'd90;

	typedef struct packed {
		logic [THR_W-1:0] primary_threshold;
		logic [THR_W-1:0] end_threshold;
	} cfg_t;

	typedef struct packed {
		logic  to_video_pulse;
		logic  back_to_live_pulse;
		logic  end_confirmed_pulse;
		mode_t mode;
	} result_t;

endpackage

// ===== hdl/dtf_in_if.sv =====
interface dtf_in_if;
	logic valid;
	logic ready;
	logic primary_seen;
	logic end_seen;

	modport source (output valid, primary_seen, end_seen, input ready);
	modport sink   (input valid, primary_seen, end_seen, output ready);
	modport mon    (input valid, ready, primary_seen, end_seen);
endinterface

// ===== hdl/dtf_out_if.sv =====
interface dtf_out_if;
	logic       valid;
	logic       ready;
	logic       to_video_pulse;
	logic       back_to_live_pulse;
	logic       end_confirmed_pulse;
	logic [1:0] mode;

	modport source (output valid, to_video_pulse, back_to_live_pulse, end_confirmed_pulse, mode,
		input ready);
	modport sink   (input valid, to_video_pulse, back_to_live_pulse, end_confirmed_pulse, mode,
		output ready);
	modport mon    (input valid, ready, to_video_pulse, back_to_live_pulse, end_confirmed_pulse,
		mode);
endinterface

// ===== hdl/dtf_cfg.sv =====
module dtf_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [dtf_pkg::CFG_IDX_W-1:0] index,
	input  logic [dtf_pkg::THR_W-1:0]     data,
	output dtf_pkg::cfg_t                 cfg
);
	import dtf_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.primary_threshold <= THR_RESET;
			cfg_q.end_threshold     <= THR_RESET;
		end else if (we) begin
			case (index)
				REG_PRIMARY_THR: cfg_q.primary_threshold <= data;
				REG_END_THR:     cfg_q.end_threshold     <= data;
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// ===== hdl/dtf_core.sv =====
module dtf_core #(
	parameter int unsigned COUNTER_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              primary_seen,
	input  logic              end_seen,
	input  dtf_pkg::cfg_t     cfg,
	output dtf_pkg::result_t  result
);
	import dtf_pkg::*;

	// compare width covers both counter and threshold
	localparam int unsigned CMP_W = (COUNTER_BITS > THR_W) ? COUNTER_BITS : THR_W;

	mode_t                  mode_q, mode_nx;
	logic [COUNTER_BITS-1:0] pcnt_q, pcnt_nx, pcnt_inc;
	logic [COUNTER_BITS-1:0] ecnt_q, ecnt_nx;
	logic [ABSENT_W-1:0]     acnt_q, acnt_nx;
	logic                    latched_q, latched_nx;
	logic                    end_conf, prim_conf;
	logic                    to_video, back, confirmed;

	always_comb begin
		// saturating frame counters
		ecnt_nx = end_seen ? ((ecnt_q == '1) ? ecnt_q : ecnt_q + 1'b1) : '0;
		acnt_nx = end_seen ? '0 : ((acnt_q == '1) ? acnt_q : acnt_q + 1'b1);
		pcnt_inc = primary_seen ? ((pcnt_q == '1) ? pcnt_q : pcnt_q + 1'b1) : '0;

		end_conf  = CMP_W'(ecnt_nx) >= CMP_W'(cfg.end_threshold);
		prim_conf = CMP_W'(pcnt_inc) >= CMP_W'(cfg.primary_threshold);

		mode_nx    = mode_q;
		pcnt_nx    = pcnt_q;
		latched_nx = latched_q;
		to_video   = 1'b0;
		back       = 1'b0;
		confirmed  = 1'b0;

		if (end_conf) begin
			// end of round wins; only acts on a fresh confirm
			if (!latched_q) begin
				latched_nx = 1'b1;
				pcnt_nx    = '0;
				back       = (mode_q == MODE_VIDEO) || (mode_q == MODE_LIVE);
				confirmed  = 1'b1;
				mode_nx    = MODE_IDLE;
			end
		end else begin
			if (acnt_nx >= ABSENT_LIMIT) begin
				latched_nx = 1'b0;
			end
			pcnt_nx = pcnt_inc;
			if (prim_conf) begin
				to_video = (mode_q != MODE_VIDEO);
				mode_nx  = MODE_VIDEO;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			pcnt_q    <= '0;
			ecnt_q    <= '0;
			acnt_q    <= '0;
			latched_q <= 1'b0;
		end else if (accept) begin
			mode_q    <= mode_nx;
			pcnt_q    <= pcnt_nx;
			ecnt_q    <= ecnt_nx;
			acnt_q    <= acnt_nx;
			latched_q <= latched_nx;
		end
	end

	assign result.to_video_pulse      = to_video;
	assign result.back_to_live_pulse  = back;
	assign result.end_confirmed_pulse = confirmed;
	assign result.mode                = mode_nx;
endmodule

// ===== hdl/dtf_out_stage.sv =====
module dtf_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             take,
	input  dtf_pkg::result_t data,
	output logic             valid,
	output dtf_pkg::result_t q
);
	import dtf_pkg::*;

	logic    valid_q;
	result_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data;
		end
	end

	assign valid = valid_q;
	assign q     = data_q;
endmodule

// ===== hdl/debounced_two_flag_mode_switch_top.sv =====
// channel   dir   word                                      handshake
// in_ch     in    primary_seen, end_seen                    valid / ready
// out_ch    out   to_video_pulse, back_to_live_pulse,       valid / ready
//                 end_confirmed_pulse, mode
// cfg       in    cfg_we, cfg_index, cfg_data               write enable only
//
// one word accepted per clock while in_ch.ready; its result goes to the output register
// frame state (mode, debounce counters, latch) moves on the accepting edge
// in_ch.ready is high whenever the output register is empty or being read this cycle
// arst_n clears the frame state, the output valid and loads both thresholds with 3
module debounced_two_flag_mode_switch_top #(
	parameter int unsigned COUNTER_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dtf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dtf_pkg::THR_W-1:0]     cfg_data,
	dtf_in_if.sink                        in_ch,
	dtf_out_if.source                     out_ch
);
	import dtf_pkg::*;

	cfg_t    cfg;
	result_t res_comb;
	result_t res_q;
	logic    out_valid;
	logic    in_ready;
	logic    in_accept;

	// output register frees up in the same cycle it is read
	assign in_ready  = !out_valid || out_ch.ready;
	assign in_accept = in_ch.valid && in_ready;

	// threshold registers
	dtf_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// debounce counters, latch and mode, next-state logic
	dtf_core #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (in_accept),
		.primary_seen (in_ch.primary_seen),
		.end_seen     (in_ch.end_seen),
		.cfg          (cfg),
		.result       (res_comb)
	);

	// result register towards the sink
	dtf_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (in_accept),
		.take   (out_ch.ready),
		.data   (res_comb),
		.valid  (out_valid),
		.q      (res_q)
	);

	assign in_ch.ready                = in_ready;
	assign out_ch.valid               = out_valid;
	assign out_ch.to_video_pulse      = res_q.to_video_pulse;
	assign out_ch.back_to_live_pulse  = res_q.back_to_live_pulse;
	assign out_ch.end_confirmed_pulse = res_q.end_confirmed_pulse;
	assign out_ch.mode                = res_q.mode;
endmodule

// ===== hdl/dtf_check.sv =====
module dtf_check (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       to_video_pulse,
	input logic       back_to_live_pulse,
	input logic       end_confirmed_pulse,
	input logic [1:0] mode
);
	import dtf_pkg::*;

	// a held result stays valid and keeps its mode and end confirm
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mode)
			&& $stable(end_confirmed_pulse))
		else $error("output word changed while stalled");

	// no result without an accepted word
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) && !(in_valid && in_ready) |=> !out_valid)
		else $error("result appeared without input");

	// entering video leaves the mode at video, with no end confirm
	a_video_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && to_video_pulse |-> mode == MODE_VIDEO
			&& !end_confirmed_pulse)
		else $error("video pulse with wrong mode");

	// switch-back only comes with a fresh end confirm into idle
	a_back_conf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && back_to_live_pulse |-> end_confirmed_pulse
			&& mode == MODE_IDLE)
		else $error("switch-back pulse without end confirm");
endmodule

bind debounced_two_flag_mode_switch_top dtf_check u_dtf_check (
	.clk                 (clk),
	.arst_n              (arst_n),
	.in_valid            (in_ch.valid),
	.in_ready            (in_ch.ready),
	.out_valid           (out_ch.valid),
	.out_ready           (out_ch.ready),
	.to_video_pulse      (out_ch.to_video_pulse),
	.back_to_live_pulse  (out_ch.back_to_live_pulse),
	.end_confirmed_pulse (out_ch.end_confirmed_pulse),
	.mode                (out_ch.mode)
);

// ===== dv/mode_switch_checker.sv =====
`timescale 1ns / 100ps

module mode_switch_checker #(
	parameter int unsigned COUNTER_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dtf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dtf_pkg::THR_W-1:0]     cfg_data,
	input  logic                          wrap_up,
	dtf_in_if.mon                         in_mon,
	dtf_out_if.mon                        out_mon,
	output int unsigned                   pending,
	output int unsigned                   fail_count,
	output int unsigned                   results_seen,
	output int unsigned                   video_entries,
	output int unsigned                   round_ends,
	output int unsigned                   live_returns
);
	import dtf_pkg::*;

	localparam logic [COUNTER_BITS-1:0] RUN_MAX = '1;

	// own copy of the thresholds and the frame state
	logic [THR_W-1:0]        primary_thr;
	logic [THR_W-1:0]        end_thr;
	mode_t                   mode_now;
	logic [COUNTER_BITS-1:0] primary_run;
	logic [COUNTER_BITS-1:0] end_run;
	logic [ABSENT_W-1:0]     absent_run;
	logic                    round_latched;
	bit                      wrapped;

	result_t expected_results[$];

	task automatic report_mismatch(input string what);
		fail_count++;
		$display("%0t checker: word %0d: %s", $realtime, results_seen, what);
	endtask

	// one frame of the mode switch: moves the state and returns the word it yields
	function automatic result_t next_frame_result(input logic seen_primary, input logic seen_end);
		result_t r;
		r = '0;
		if (seen_end) begin
			if (end_run != RUN_MAX)
				end_run++;
			absent_run = '0;
		end else begin
			end_run = '0;
			if (absent_run != '1)
				absent_run++;
		end
		if (32'(end_run) >= 32'(end_thr)) begin
			// end of round wins the frame; only a fresh confirmation acts
			if (!round_latched) begin
				round_latched = 1'b1;
				primary_run = '0;
				r.back_to_live_pulse = (mode_now == MODE_VIDEO) || (mode_now == MODE_LIVE);
				r.end_confirmed_pulse = 1'b1;
				mode_now = MODE_IDLE;
			end
		end else begin
			if (absent_run >= ABSENT_LIMIT)
				round_latched = 1'b0;
			if (seen_primary) begin
				if (primary_run != RUN_MAX)
					primary_run++;
			end else begin
				primary_run = '0;
			end
			if (32'(primary_run) >= 32'(primary_thr)) begin
				r.to_video_pulse = (mode_now != MODE_VIDEO);
				mode_now = MODE_VIDEO;
			end
		end
		r.mode = mode_now;
		return r;
	endfunction

	task automatic check_result();
		result_t want;
		results_seen++;
		if (expected_results.size() == 0) begin
			report_mismatch("result word with nothing expected");
			return;
		end
		want = expected_results.pop_front();
		if (out_mon.to_video_pulse !== want.to_video_pulse)
			report_mismatch($sformatf("to_video_pulse got %b expected %b",
				out_mon.to_video_pulse, want.to_video_pulse));
		if (out_mon.back_to_live_pulse !== want.back_to_live_pulse)
			report_mismatch($sformatf("back_to_live_pulse got %b expected %b",
				out_mon.back_to_live_pulse, want.back_to_live_pulse));
		if (out_mon.end_confirmed_pulse !== want.end_confirmed_pulse)
			report_mismatch($sformatf("end_confirmed_pulse got %b expected %b",
				out_mon.end_confirmed_pulse, want.end_confirmed_pulse));
		if (out_mon.mode !== want.mode)
			report_mismatch($sformatf("mode got %0d expected %0d", out_mon.mode, want.mode));
		if (want.to_video_pulse)
			video_entries++;
		if (want.end_confirmed_pulse)
			round_ends++;
		if (want.back_to_live_pulse)
			live_returns++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primary_thr = THR_RESET;
			end_thr = THR_RESET;
			mode_now = MODE_IDLE;
			primary_run = '0;
			end_run = '0;
			absent_run = '0;
			round_latched = 1'b0;
			wrapped = 1'b0;
			expected_results.delete();
			fail_count = 0;
			results_seen = 0;
			video_entries = 0;
			round_ends = 0;
			live_returns = 0;
			pending <= 0;
		end else begin
			// result first: a word leaving now never belongs to the one entering now
			if (out_mon.valid && out_mon.ready)
				check_result();
			if (in_mon.valid && in_mon.ready)
				expected_results.push_back(next_frame_result(in_mon.primary_seen,
					in_mon.end_seen));
			if (cfg_we) begin
				case (cfg_index)
					REG_PRIMARY_THR: primary_thr = cfg_data;
					REG_END_THR:     end_thr = cfg_data;
					default: ;
				endcase
			end
			if (wrap_up && !wrapped) begin
				wrapped = 1'b1;
				if (expected_results.size() != 0)
					report_mismatch($sformatf("%0d result words never arrived",
						expected_results.size()));
			end
			pending <= expected_results.size();
		end
	end

endmodule

// ===== dv/debounced_two_flag_mode_switch_top_test.sv =====
`timescale 1ns / 100ps

module debounced_two_flag_mode_switch_top_test;
	import dtf_pkg::*;

	localparam int unsigned COUNTER_BITS = 8;
	localparam int unsigned HOLD_CYCLES = 300;     // long output hold-off
	localparam int unsigned WATCHDOG_LIMIT = 3000; // cycles with no word moving

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [THR_W-1:0]     cfg_data;
	logic                 wrap_up;

	dtf_in_if  in_ch ();
	dtf_out_if out_ch ();

	int unsigned pending;
	int unsigned fail_count;
	int unsigned results_seen;
	int unsigned video_entries;
	int unsigned round_ends;
	int unsigned live_returns;

	// shared between stimulus and receiver; each variable has a single writer
	bit          idle_on = 1'b0;
	int unsigned hold_asks = 0;
	int unsigned holds_done = 0;

	// bookkeeping for the episode generator and the summary
	logic [THR_W-1:0] primary_thr_set = THR_RESET;
	logic [THR_W-1:0] end_thr_set = THR_RESET;
	int unsigned      words_sent = 0;
	int unsigned      settings_used = 1;

	debounced_two_flag_mode_switch_top #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	mode_switch_checker #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.wrap_up      (wrap_up),
		.in_mon       (in_ch),
		.out_mon      (out_ch),
		.pending      (pending),
		.fail_count   (fail_count),
		.results_seen (results_seen),
		.video_entries(video_entries),
		.round_ends   (round_ends),
		.live_returns (live_returns)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// idle gap ahead of a word: mostly none or short, now and then long
	function automatic int unsigned gap_len();
		int unsigned r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// length of a flag run, centred on thresholds up to 8 so both sides of them are hit, else 1 to 8
	function automatic int unsigned run_span(input logic [THR_W-1:0] thr);
		int unsigned t;
		t = 32'(thr);
		if (t > 8)
			return $urandom_range(1, 8);
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, t + 2);
		return t + $urandom_range(0, 2);
	endfunction

	// offer one frame word and hold it until it is taken; starts and ends on a rising edge
	task automatic send_word(input logic seen_primary, input logic seen_end);
		int unsigned gap;
		gap = gap_len();
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.primary_seen <= seen_primary;
		in_ch.end_seen <= seen_end;
		do
			@(posedge clk);
		while (!in_ch.ready);
		words_sent++;
	endtask

	// thresholds change only with the block drained; one result per word, so
	// an empty expectation queue, once the input has been dropped, means nothing in flight
	task automatic set_thresholds(input logic [THR_W-1:0] primary_thr,
			input logic [THR_W-1:0] end_thr);
		in_ch.valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_PRIMARY_THR;
		cfg_data <= primary_thr;
		@(posedge clk);
		cfg_index <= REG_END_THR;
		cfg_data <= end_thr;
		@(posedge clk);
		cfg_we <= 1'b0;
		primary_thr_set = primary_thr;
		end_thr_set = end_thr;
		settings_used++;
	endtask

	// one round as it looks on screen: primary hint, end text, then a quiet stretch;
	// quiet stretches either stay short, sit around the latch release or run past it
	task automatic play_round();
		int unsigned n_primary;
		int unsigned n_end;
		int unsigned n_absent;
		int unsigned i;
		n_primary = run_span(primary_thr_set);
		n_end = run_span(end_thr_set);
		case ($urandom_range(0, 4))
			0, 1: begin
				n_absent = $urandom_range(1, 6);
			end
			2, 3: begin
				n_absent = $urandom_range(86, 94);
			end
			default: begin
				n_absent = $urandom_range(95, 140);
			end
		endcase
		for (i = 0; i < n_primary; i++)
			send_word(1'b1, $urandom_range(0, 9) == 0);
		for (i = 0; i < n_end; i++)
			send_word(1'($urandom_range(0, 1)), 1'b1);
		for (i = 0; i < n_absent; i++)
			send_word($urandom_range(0, 3) == 0, 1'b0);
	endtask

	// mostly whole rounds, the rest short bursts of random flags
	task automatic run_random(input int unsigned n_words);
		int unsigned stop_at;
		int unsigned burst;
		int unsigned i;
		stop_at = words_sent + n_words;
		while (words_sent < stop_at) begin
			if ($urandom_range(0, 4) == 0)
				idle_on = ~idle_on;
			if ($urandom_range(0, 9) < 7) begin
				play_round();
			end else begin
				burst = $urandom_range(1, 8);
				for (i = 0; i < burst; i++)
					send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	// receiver: random stalls, plus the long hold-off when the stimulus asks for it
	initial begin : receiver
		int unsigned n;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_asks != holds_done) begin
				holds_done++;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				n = gap_len();
				if (n != 0) begin
					out_ch.ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
			out_ch.ready <= 1'b1;
		end
	end

	// watchdog: ends the run if no word moves on either side for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no word moved for %0d cycles, %0d results still due",
			WATCHDOG_LIMIT, pending);
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		int unsigned i;
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_PRIMARY_THR;
		cfg_data <= '0;
		wrap_up <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.primary_seen <= 1'b0;
		in_ch.end_seen <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset thresholds of 3, back to back
		idle_on = 1'b0;
		// primary confirmed on its third frame, held on the fourth
		for (i = 0; i < 4; i++)
			send_word(1'b1, 1'b0);
		send_word(1'b0, 1'b0);
		// end of round from video: switch-back and confirmation on the third frame,
		// primary ignored while the end flag stays confirmed
		send_word(1'b1, 1'b1);
		send_word(1'b1, 1'b1);
		send_word(1'b0, 1'b1);
		send_word(1'b1, 1'b1);
		// latch still set: primary may take the mode to video again
		for (i = 0; i < 3; i++)
			send_word(1'b1, 1'b0);
		// confirmed but latched: no pulses, mode left alone
		for (i = 0; i < 3; i++)
			send_word(1'b0, 1'b1);
		send_word(1'b0, 1'b0);

		// long output hold-off with the input offered non-stop, so the block backs up
		hold_asks++;
		for (i = 0; i < 20; i++)
			send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		run_random(40);

		// zero thresholds: met on every frame
		set_thresholds('0, '0);
		run_random(10);

		// largest thresholds: reached only on a saturated counter
		set_thresholds('1, '1);
		idle_on = 1'b0;
		for (i = 0; i < 258; i++)
			send_word(1'b1, 1'b0);
		for (i = 0; i < 258; i++)
			send_word(1'b1, 1'b1);
		// quiet long enough to release the latch and saturate the absence count
		for (i = 0; i < 130; i++)
			send_word(1'b0, 1'b0);
		run_random(10);

		// mixed settings, the extremes among them
		set_thresholds('0, 8'd3);
		run_random(10);
		set_thresholds(8'd3, '1);
		run_random(10);
		set_thresholds(8'd1, 8'd1);
		run_random(10);
		set_thresholds(8'd2, 8'd5);
		run_random(10);
		for (i = 0; i < 2; i++) begin
			set_thresholds(8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)));
			run_random(10);
		end

		// drain, let the tail settle, then ask the checker for leftovers
		in_ch.valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		wrap_up <= 1'b1;
		repeat (2) @(posedge clk);

		$display("run summary: %0d frame words, %0d results checked, %0d threshold settings",
			words_sent, results_seen, settings_used);
		$display("run summary: %0d video entries, %0d round ends, %0d switch-backs",
			video_entries, round_ends, live_returns);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== debounced_two_flag_mode_switch_top.f =====
hdl/dtf_pkg.sv
hdl/dtf_in_if.sv
hdl/dtf_out_if.sv
hdl/dtf_cfg.sv
hdl/dtf_core.sv
hdl/dtf_out_stage.sv
hdl/debounced_two_flag_mode_switch_top.sv
hdl/dtf_check.sv
dv/mode_switch_checker.sv
dv/debounced_two_flag_mode_switch_top_test.sv
